FILE: src/segment_classify_and_split_top_defines.svh
// assertion macros shared by the checker
`ifndef SEGMENT_CLASSIFY_AND_SPLIT_TOP_DEFINES_SVH
`define SEGMENT_CLASSIFY_AND_SPLIT_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("segment classify check failed");

// next-cycle implication, quiet during reset
`define SCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("segment classify check failed");

`endif

FILE: src/scs_pkg.sv
package scs_pkg;

  typedef enum logic [1:0] {
    POS_FRONT  = 2'd0,
    POS_BEHIND = 2'd1,
    POS_CROSS  = 2'd2,
    POS_ON     = 2'd3
  } pos_e;

endpackage

FILE: src/scs_cell.sv
module scs_cell #(
  parameter int W   = 16,
  parameter int BIT = 0,
  parameter int SW  = 69
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*W+3:0]      n_i,
  input  logic [2*W+3:0]      den_i,
  input  logic [W+1:0]        magx_i,
  input  logic [W+1:0]        magy_i,
  input  logic [W+1:0]        qx_i,
  input  logic [2*W+3:0]      rx_i,
  input  logic [W+1:0]        qy_i,
  input  logic [2*W+3:0]      ry_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [2*W+3:0]      n_o,
  output logic [2*W+3:0]      den_o,
  output logic [W+1:0]        magx_o,
  output logic [W+1:0]        magy_o,
  output logic [W+1:0]        qx_o,
  output logic [2*W+3:0]      rx_o,
  output logic [W+1:0]        qy_o,
  output logic [2*W+3:0]      ry_o,
  output logic [SW-1:0]       side_o
);

  localparam int DW = 2 * W + 4;
  localparam int TW = DW + 2;
  localparam int QW = W + 2;

  // one restoring step with a digit of up to two
  function automatic logic [TW+1:0] div_step(input logic [DW-1:0] r, input logic b,
                                             input logic [DW-1:0] n, input logic [DW-1:0] den);
    logic [TW-1:0] t;
    logic [1:0]    k;
    t = {1'b0, r, 1'b0} + (b ? TW'(n) : TW'(0));
    k = 2'd0;
    if (t >= TW'(den)) begin
      t = t - TW'(den);
      k = 2'd1;
    end
    if (t >= TW'(den)) begin
      t = t - TW'(den);
      k = 2'd2;
    end
    return {k, t};
  endfunction

  logic [TW+1:0] stx, sty;
  logic [W+1:0]  qx_d, qy_d;

  always_comb begin
    stx  = div_step(rx_i, magx_i[BIT], n_i, den_i);
    sty  = div_step(ry_i, magy_i[BIT], n_i, den_i);
    qx_d = {qx_i[QW-2:0], 1'b0} + QW'(stx[TW+1:TW]);
    qy_d = {qy_i[QW-2:0], 1'b0} + QW'(sty[TW+1:TW]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      n_o    <= n_i;
      den_o  <= den_i;
      magx_o <= magx_i;
      magy_o <= magy_i;
      qx_o   <= qx_d;
      qy_o   <= qy_d;
      rx_o   <= stx[DW-1:0];
      ry_o   <= sty[DW-1:0];
      side_o <= side_i;
    end
  end

endmodule

FILE: src/segment_classify_and_split_top.sv
// pipeline: stage 1 register, stage 2 register, the row of divider cells, then the output register
// throughput: one word per cycle while the pipe is not stalled, set by the row of COORD_BITS + 2 divider cells
// that each resolve one quotient bit of both coordinates and hand on whenever the pipe advances
// the whole pipe stalls only when the output register is full and not taken
// reset: asynchronous active low, clears the valid bits; the data registers are not reset
module segment_classify_and_split_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] splitter_start_x_i,
  input  logic signed [COORD_BITS-1:0] splitter_start_y_i,
  input  logic signed [COORD_BITS-1:0] splitter_end_x_i,
  input  logic signed [COORD_BITS-1:0] splitter_end_y_i,
  input  logic                         splitter_faces_front_i,
  input  logic signed [COORD_BITS-1:0] segment_start_x_i,
  input  logic signed [COORD_BITS-1:0] segment_start_y_i,
  input  logic signed [COORD_BITS-1:0] segment_end_x_i,
  input  logic signed [COORD_BITS-1:0] segment_end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   position_o,
  output logic                         start_in_front_o,
  output logic                         split_valid_o,
  output logic signed [COORD_BITS-1:0] cross_x_o,
  output logic signed [COORD_BITS-1:0] cross_y_o
);

  localparam int W  = COORD_BITS;
  localparam int PW = 2 * W + 2;      // product width
  localparam int DW = 2 * W + 4;      // cross product, divisor and remainder width
  localparam int QW = W + 2;          // quotient and magnitude width
  localparam int NC = W + 2;          // number of divider cells
  localparam int SW = 4 * W + 5;      // sideband: pos, sif, negx, negy, x3, y3, x4, y4
  localparam int MW = W + 3;          // width of the reconstructed point

  // whole pipe moves whenever the output register can take a word
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // ---------------------------------------------------------------- stage 1
  // edge vectors and the four cross product terms
  logic signed [W:0]    ex, ey, ax3, ay3, ax4, ay4;
  logic signed [PW-1:0] p1_d, p2_d, p3_d, p4_d;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [W-1:0]  x3_q1, y3_q1, x4_q1, y4_q1;
  logic                 faces_q;
  logic                 v1_q;

  always_comb begin
    ex   = {splitter_end_x_i[W-1], splitter_end_x_i}
         - {splitter_start_x_i[W-1], splitter_start_x_i};
    ey   = {splitter_end_y_i[W-1], splitter_end_y_i}
         - {splitter_start_y_i[W-1], splitter_start_y_i};
    ax3  = {segment_start_x_i[W-1], segment_start_x_i}
         - {splitter_start_x_i[W-1], splitter_start_x_i};
    ay3  = {segment_start_y_i[W-1], segment_start_y_i}
         - {splitter_start_y_i[W-1], splitter_start_y_i};
    ax4  = {segment_end_x_i[W-1], segment_end_x_i}
         - {splitter_start_x_i[W-1], splitter_start_x_i};
    ay4  = {segment_end_y_i[W-1], segment_end_y_i}
         - {splitter_start_y_i[W-1], splitter_start_y_i};
    p1_d = PW'(ax3) * PW'(ey);
    p2_d = PW'(ay3) * PW'(ex);
    p3_d = PW'(ax4) * PW'(ey);
    p4_d = PW'(ay4) * PW'(ex);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      p3_q    <= p3_d;
      p4_q    <= p4_d;
      x3_q1   <= segment_start_x_i;
      y3_q1   <= segment_start_y_i;
      x4_q1   <= segment_end_x_i;
      y4_q1   <= segment_end_y_i;
      faces_q <= splitter_faces_front_i;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // side of each endpoint, classification, divider operands
  logic signed [DW-1:0] d3, d4;
  logic                 z3, z4, f3, f4;
  scs_pkg::pos_e        pos_d;
  logic [DW-1:0]        n_d, den_d;
  logic signed [W:0]    dxx, dyy;
  logic [QW-1:0]        magx_d, magy_d;
  logic [SW-1:0]        side_d;

  always_comb begin
    d3 = DW'(p1_q) - DW'(p2_q);
    d4 = DW'(p3_q) - DW'(p4_q);
    z3 = (d3 == '0);
    z4 = (d4 == '0);
    f3 = !z3 && ((d3 < 0) == faces_q);
    f4 = !z4 && ((d4 < 0) == faces_q);
    if (z3 && z4) begin
      pos_d = scs_pkg::POS_ON;
    end else if (!(!z3 && !f3) && !(!z4 && !f4)) begin
      pos_d = scs_pkg::POS_FRONT;
    end else if (!f3 && !f4) begin
      pos_d = scs_pkg::POS_BEHIND;
    end else begin
      pos_d = scs_pkg::POS_CROSS;
    end
    n_d    = (d3 < 0) ? DW'(-d3) : DW'(d3);
    den_d  = n_d + ((d4 < 0) ? DW'(-d4) : DW'(d4));
    dxx    = {x4_q1[W-1], x4_q1} - {x3_q1[W-1], x3_q1};
    dyy    = {y4_q1[W-1], y4_q1} - {y3_q1[W-1], y3_q1};
    magx_d = (dxx < 0) ? QW'(-dxx) : QW'(dxx);
    magy_d = (dyy < 0) ? QW'(-dyy) : QW'(dyy);
    side_d = {pos_d, f3, dxx[W], dyy[W], x3_q1, y3_q1, x4_q1, y4_q1};
  end

  // ---------------------------------------------------------------- divider row
  logic          cv   [0:NC];
  logic [DW-1:0] cn   [0:NC];
  logic [DW-1:0] cden [0:NC];
  logic [QW-1:0] cmx  [0:NC];
  logic [QW-1:0] cmy  [0:NC];
  logic [QW-1:0] cqx  [0:NC];
  logic [QW-1:0] cqy  [0:NC];
  logic [DW-1:0] crx  [0:NC];
  logic [DW-1:0] cry  [0:NC];
  logic [SW-1:0] cside[0:NC];

  // head of the row is the stage 2 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      cn[0]    <= n_d;
      cden[0]  <= den_d;
      cmx[0]   <= magx_d;
      cmy[0]   <= magy_d;
      cqx[0]   <= '0;
      cqy[0]   <= '0;
      crx[0]   <= '0;
      cry[0]   <= '0;
      cside[0] <= side_d;
    end
  end

  // one cell per quotient bit, most significant first
  for (genvar g = 0; g < NC; g++) begin : g_cell
    scs_cell #(
      .W  (W),
      .BIT(W + 1 - g),
      .SW (SW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(cv[g]),
      .n_i    (cn[g]),
      .den_i  (cden[g]),
      .magx_i (cmx[g]),
      .magy_i (cmy[g]),
      .qx_i   (cqx[g]),
      .rx_i   (crx[g]),
      .qy_i   (cqy[g]),
      .ry_i   (cry[g]),
      .side_i (cside[g]),
      .valid_o(cv[g+1]),
      .n_o    (cn[g+1]),
      .den_o  (cden[g+1]),
      .magx_o (cmx[g+1]),
      .magy_o (cmy[g+1]),
      .qx_o   (cqx[g+1]),
      .rx_o   (crx[g+1]),
      .qy_o   (cqy[g+1]),
      .ry_o   (cry[g+1]),
      .side_o (cside[g+1])
    );
  end

  // ---------------------------------------------------------------- finish
  // rebuild the point, truncate towards zero, bounding box test
  logic [1:0]           pos_f;
  logic                 sif_f, negx_f, negy_f;
  logic signed [W-1:0]  x3_f, y3_f, x4_f, y4_f;
  logic signed [MW-1:0] mx, my, sx3, sy3, sx4, sy4;
  logic                 inbox, split_d;

  always_comb begin
    {pos_f, sif_f, negx_f, negy_f, x3_f, y3_f, x4_f, y4_f} = cside[NC];
    sx3 = MW'(x3_f);
    sy3 = MW'(y3_f);
    sx4 = MW'(x4_f);
    sy4 = MW'(y4_f);
    mx  = negx_f ? sx3 - MW'(cqx[NC]) : sx3 + MW'(cqx[NC]);
    my  = negy_f ? sy3 - MW'(cqy[NC]) : sy3 + MW'(cqy[NC]);
    if (crx[NC] != '0) begin
      if (!negx_f && mx < 0) mx = mx + MW'(1);
      if (negx_f && mx > 0)  mx = mx - MW'(1);
    end
    if (cry[NC] != '0) begin
      if (!negy_f && my < 0) my = my + MW'(1);
      if (negy_f && my > 0)  my = my - MW'(1);
    end
    inbox = (mx >= ((sx3 < sx4) ? sx3 : sx4)) && (mx <= ((sx3 < sx4) ? sx4 : sx3))
         && (my >= ((sy3 < sy4) ? sy3 : sy4)) && (my <= ((sy3 < sy4) ? sy4 : sy3));
    split_d = (pos_f == scs_pkg::POS_CROSS) && inbox;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= cv[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && cv[NC]) begin
      position_o       <= pos_f;
      start_in_front_o <= (pos_f == scs_pkg::POS_CROSS) && sif_f;
      split_valid_o    <= split_d;
      cross_x_o        <= split_d ? mx[W-1:0] : '0;
      cross_y_o        <= split_d ? my[W-1:0] : '0;
    end
  end

endmodule

FILE: src/scs_checker.sv
`include "segment_classify_and_split_top_defines.svh"

module scs_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [1:0]                   position_o,
  input logic                         start_in_front_o,
  input logic                         split_valid_o,
  input logic signed [COORD_BITS-1:0] cross_x_o,
  input logic signed [COORD_BITS-1:0] cross_y_o
);

  // a waiting word holds
  `SCS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(position_o))

  // a split point only comes with a crossing
  `SCS_ASSERT_NOW(a_split_cross, out_valid_o && split_valid_o, position_o == scs_pkg::POS_CROSS)

  // no valid split means a zero point
  `SCS_ASSERT_NOW(a_zero_point, out_valid_o && !split_valid_o, cross_x_o == '0 && cross_y_o == '0)

  // front flag only on crossings
  `SCS_ASSERT_NOW(a_sif_cross, out_valid_o && start_in_front_o, position_o == scs_pkg::POS_CROSS)

endmodule

bind segment_classify_and_split_top scs_checker #(.COORD_BITS(COORD_BITS)) u_scs_checker (.*);
